// File: rtl/pbb_pkg.sv
// Package for the projected box bounds block: fixed-point constants, payload structs,
// sequencer state codes and the saturation helper.
// Depends on nothing; used by rtl/projected_box_bounds_top.sv.
`default_nettype none

package pbb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_VAL   = 1 << FRAC_BITS;
  localparam int WMIN_RAW  = (ONE_VAL + 500) / 1000;
  localparam int WMIN_VAL  = (WMIN_RAW < 1) ? 1 : WMIN_RAW;

  // Clip accumulator, wide enough for three products plus the offset column.
  localparam int ACC_W  = 66 - FRAC_BITS;
  // Ratio magnitude limit is 2^47, so the magnitude needs 48 bits.
  localparam int RLIM_B = 47;
  localparam int QMAG_W = RLIM_B + 1;
  localparam int QS_W   = QMAG_W + 1;
  localparam int T_W    = QS_W + 1;
  localparam int SP_W   = T_W + 16;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int DIV_STEPS = RLIM_B;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_top;
    logic signed [31:0] rect_right;
    logic signed [31:0] rect_bottom;
    logic [3:0]         visible_corners;
  } out_item_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL  = 10'b00_0000_0010,
    S_ACC  = 10'b00_0000_0100,
    S_WCHK = 10'b00_0000_1000,
    S_DCHK = 10'b00_0001_0000,
    S_DIV  = 10'b00_0010_0000,
    S_SMUL = 10'b00_0100_0000,
    S_SSAT = 10'b00_1000_0000,
    S_UPD  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [SP_W-1:0] v);
    logic signed [SP_W-1:0] hi;
    logic signed [SP_W-1:0] lo;
    hi = SP_W'(32'sh7fff_ffff);
    lo = -hi - SP_W'(1);
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/projected_box_bounds_top.sv
// Top level of the projected box bounds block: matrix store, shared multiplier and
// divider under one sequencer, APB register port and output register.
// Depends on rtl/pbb_pkg.sv.
`default_nettype none

// The block holds a 4x4 row-major projection matrix in signed Q16.16, loaded one
// element per input transfer (op = 0). A box transfer (op = 1) projects the eight
// corners of the box and returns one result transfer: the screen rectangle that
// bounds the corners whose w is at least 0.001, and their count. All arithmetic
// goes through one 32x32 multiplier, one restoring divider that yields one quotient
// bit per cycle, and one scaling multiplier, stepped by a small sequencer. A corner
// that fails the w test costs three matrix terms (multiply, then accumulate) and
// the test. A visible corner costs the w row, then for each of x and y the row, one
// range check, 47 division steps, one scaling multiply and one saturation step, and
// then one update step; a ratio that saturates skips its 47 division steps. The
// result waits in the output register until the receiver takes it. The input is
// stalled for the whole of a box and until its result transfer has been taken.
// Screen width and height are written over the APB port at byte addresses 0 and 4.
module projected_box_bounds_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pbb_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pbb_pkg::out_item_t     out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int ACC_W  = pbb_pkg::ACC_W;
  localparam int QMAG_W = pbb_pkg::QMAG_W;
  localparam int QS_W   = pbb_pkg::QS_W;
  localparam int T_W    = pbb_pkg::T_W;
  localparam int SP_W   = pbb_pkg::SP_W;
  localparam int NUM_W  = pbb_pkg::NUM_W;
  localparam int FB     = pbb_pkg::FRAC_BITS;
  localparam int RB     = pbb_pkg::RLIM_B;
  localparam int SATSH  = RB - FB;

  // Configuration registers.
  logic [13:0] width_q, height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd1920;
      height_q <= 14'd1080;
    end else if (cfg_wr) begin
      if ({1'b0, paddr[2]} == pbb_pkg::REG_WIDTH) begin
        width_q <= pwdata[13:0];
      end else begin
        height_q <= pwdata[13:0];
      end
    end
  end

  always_comb begin
    if ({1'b0, paddr[2]} == pbb_pkg::REG_WIDTH) begin
      prdata = {18'd0, width_q};
    end else begin
      prdata = {18'd0, height_q};
    end
  end

  // Sequencer and datapath registers.
  pbb_pkg::state_e state_q;
  logic signed [31:0] mat_q [16];
  logic signed [31:0] lo_q [3];
  logic signed [31:0] hi_q [3];
  logic [2:0]  corner_q;
  logic [1:0]  phase_q;   // 0: w row, 1: x row, 2: y row
  logic [1:0]  term_q;
  logic signed [ACC_W-1:0] acc_q, w_q;
  logic signed [63:0] prod_q;
  logic        neg_q;
  logic [ACC_W:0] rem_q;
  logic [RB-1:0] num_q;
  logic [QMAG_W-1:0] quot_q;
  logic [5:0]  div_cnt_q;
  logic signed [SP_W-1:0] sprod_q;
  logic signed [31:0] sx_q;
  logic signed [31:0] left_q, top_q, right_q, bottom_q;
  logic [3:0]  count_q;
  logic        out_valid_q;

  logic        in_acc;
  logic [1:0]  mrow, mrow_next;
  logic [1:0]  phase_next;
  logic signed [31:0] p_sel;
  logic signed [63:0] prod_term;
  logic [ACC_W-1:0] n_mag;
  logic [ACC_W+SATSH-1:0] n_ext, d_ext;
  logic [NUM_W-1:0] num_full;
  logic [ACC_W+1:0] trial;
  logic [ACC_W+1:0] d_wide;
  logic signed [QS_W-1:0] q_signed;
  logic signed [T_W-1:0]  t_val;
  logic signed [15:0]     scale;
  logic signed [31:0]     s_val;
  logic signed [31:0]     init_l, init_t;

  assign in_stall_o  = (state_q != pbb_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  assign out_data_o.rect_left       = left_q;
  assign out_data_o.rect_top        = top_q;
  assign out_data_o.rect_right      = right_q;
  assign out_data_o.rect_bottom     = bottom_q;
  assign out_data_o.visible_corners = count_q;

  // Matrix row used by each phase: w comes from row 3, x from row 0, y from row 1.
  always_comb begin
    case (phase_q)
      2'd0:    mrow = 2'd3;
      2'd1:    mrow = 2'd0;
      default: mrow = 2'd1;
    endcase
    case (phase_next)
      2'd0:    mrow_next = 2'd3;
      2'd1:    mrow_next = 2'd0;
      default: mrow_next = 2'd1;
    endcase
  end

  always_comb begin
    case (term_q)
      2'd0:    p_sel = corner_q[0] ? hi_q[0] : lo_q[0];
      2'd1:    p_sel = corner_q[1] ? hi_q[1] : lo_q[1];
      default: p_sel = corner_q[2] ? hi_q[2] : lo_q[2];
    endcase
  end

  assign prod_term = prod_q >>> FB;

  // Divider operands.
  assign n_mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign n_ext    = {{SATSH{1'b0}}, n_mag};
  assign d_ext    = {w_q, {SATSH{1'b0}}};
  assign num_full = {n_mag, {FB{1'b0}}};
  assign d_wide   = {2'b00, w_q};
  assign trial    = {rem_q, num_q[RB-1]};

  // Scaling operands.
  assign q_signed = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
  assign t_val    = (phase_q == 2'd1) ?
                    T_W'(pbb_pkg::ONE_VAL) + T_W'(q_signed) :
                    T_W'(pbb_pkg::ONE_VAL) - T_W'(q_signed);
  assign scale    = (phase_q == 2'd1) ? $signed({2'b00, width_q}) :
                                        $signed({2'b00, height_q});
  assign s_val    = pbb_pkg::sat32(sprod_q >>> 1);

  // Initial rectangle corner, W*ONE and H*ONE saturated.
  assign init_l = pbb_pkg::sat32(SP_W'($signed({1'b0, width_q})) <<< FB);
  assign init_t = pbb_pkg::sat32(SP_W'($signed({1'b0, height_q})) <<< FB);

  always_comb begin
    phase_next = 2'd0;
    if (state_q == pbb_pkg::S_WCHK) begin
      phase_next = 2'd1;
    end else if (state_q == pbb_pkg::S_SSAT) begin
      phase_next = 2'd2;
    end
  end

  // Matrix store: loaded by op 0 transfers, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (in_acc && in_data_i.op == pbb_pkg::OP_LOAD) begin
      mat_q[in_data_i.element_index] <= in_data_i.element_value;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbb_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      corner_q    <= '0;
      phase_q     <= '0;
      term_q      <= '0;
      div_cnt_q   <= '0;
      count_q     <= '0;
    end else begin
      case (state_q)
        pbb_pkg::S_IDLE: begin
          if (in_acc && in_data_i.op == pbb_pkg::OP_PROJECT) begin
            corner_q <= '0;
            phase_q  <= 2'd0;
            term_q   <= '0;
            count_q  <= '0;
            state_q  <= pbb_pkg::S_MUL;
          end
        end
        pbb_pkg::S_MUL: begin
          state_q <= pbb_pkg::S_ACC;
        end
        pbb_pkg::S_ACC: begin
          if (term_q == 2'd2) begin
            term_q  <= '0;
            state_q <= (phase_q == 2'd0) ? pbb_pkg::S_WCHK : pbb_pkg::S_DCHK;
          end else begin
            term_q  <= term_q + 2'd1;
            state_q <= pbb_pkg::S_MUL;
          end
        end
        pbb_pkg::S_WCHK: begin
          if (acc_q < ACC_W'(pbb_pkg::WMIN_VAL)) begin
            // Corner behind the viewer: move straight to the next one.
            if (corner_q == 3'd7) begin
              out_valid_q <= 1'b1;
              state_q     <= pbb_pkg::S_OUT;
            end else begin
              corner_q <= corner_q + 3'd1;
              state_q  <= pbb_pkg::S_MUL;
            end
          end else begin
            phase_q <= 2'd1;
            state_q <= pbb_pkg::S_MUL;
          end
        end
        pbb_pkg::S_DCHK: begin
          div_cnt_q <= '0;
          state_q   <= (n_ext >= d_ext) ? pbb_pkg::S_SMUL : pbb_pkg::S_DIV;
        end
        pbb_pkg::S_DIV: begin
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(pbb_pkg::DIV_STEPS - 1)) begin
            state_q <= pbb_pkg::S_SMUL;
          end
        end
        pbb_pkg::S_SMUL: begin
          state_q <= pbb_pkg::S_SSAT;
        end
        pbb_pkg::S_SSAT: begin
          if (phase_q == 2'd1) begin
            phase_q <= 2'd2;
            state_q <= pbb_pkg::S_MUL;
          end else begin
            state_q <= pbb_pkg::S_UPD;
          end
        end
        pbb_pkg::S_UPD: begin
          count_q <= count_q + 4'd1;
          phase_q <= 2'd0;
          if (corner_q == 3'd7) begin
            out_valid_q <= 1'b1;
            state_q     <= pbb_pkg::S_OUT;
          end else begin
            corner_q <= corner_q + 3'd1;
            state_q  <= pbb_pkg::S_MUL;
          end
        end
        pbb_pkg::S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= pbb_pkg::S_IDLE;
          end
        end
        default: begin
          state_q <= pbb_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      pbb_pkg::S_IDLE: begin
        lo_q[0] <= in_data_i.min_x;
        lo_q[1] <= in_data_i.min_y;
        lo_q[2] <= in_data_i.min_z;
        hi_q[0] <= in_data_i.max_x;
        hi_q[1] <= in_data_i.max_y;
        hi_q[2] <= in_data_i.max_z;
        left_q   <= init_l;
        top_q    <= init_t;
        right_q  <= '0;
        bottom_q <= '0;
        acc_q    <= ACC_W'(mat_q[{2'd3, 2'd3}]);
      end
      pbb_pkg::S_MUL: begin
        prod_q <= mat_q[{mrow, term_q}] * p_sel;
      end
      pbb_pkg::S_ACC: begin
        acc_q <= acc_q + prod_term[ACC_W-1:0];
      end
      pbb_pkg::S_WCHK: begin
        w_q <= acc_q;
        if (acc_q < ACC_W'(pbb_pkg::WMIN_VAL)) begin
          acc_q <= ACC_W'(mat_q[{2'd3, 2'd3}]);
        end else begin
          acc_q <= ACC_W'(mat_q[{mrow_next, 2'd3}]);
        end
      end
      pbb_pkg::S_DCHK: begin
        neg_q  <= acc_q[ACC_W-1];
        quot_q <= QMAG_W'(1) << RB;
        rem_q  <= (ACC_W + 1)'(num_full[NUM_W-1:RB]);
        num_q  <= num_full[RB-1:0];
      end
      pbb_pkg::S_DIV: begin
        // The saturation marker shifts out on the first step, leaving only
        // quotient bits after the last one.
        num_q  <= {num_q[RB-2:0], 1'b0};
        quot_q <= {quot_q[QMAG_W-2:0], (trial >= d_wide)};
        if (trial >= d_wide) begin
          rem_q <= (ACC_W + 1)'(trial - d_wide);
        end else begin
          rem_q <= trial[ACC_W:0];
        end
      end
      pbb_pkg::S_SMUL: begin
        sprod_q <= SP_W'(scale) * SP_W'(t_val);
      end
      pbb_pkg::S_SSAT: begin
        if (phase_q == 2'd1) begin
          sx_q  <= s_val;
          acc_q <= ACC_W'(mat_q[{mrow_next, 2'd3}]);
        end else begin
          if (sx_q < left_q) left_q <= sx_q;
          if (sx_q > right_q) right_q <= sx_q;
          if (s_val < top_q) top_q <= s_val;
          if (s_val > bottom_q) bottom_q <= s_val;
        end
      end
      pbb_pkg::S_UPD: begin
        acc_q <= ACC_W'(mat_q[{2'd3, 2'd3}]);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: test/tb_projected_box_bounds_top.sv
// Self-checking testbench for projected_box_bounds_top: matrix loads, box projections and
// screen size writes over APB, with a transfer-level predictor of the screen rectangle.
// Depends on rtl/pbb_pkg.sv and rtl/projected_box_bounds_top.sv.
`timescale 1ns / 1ps

module tb_projected_box_bounds_top;
  import pbb_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  projected_box_bounds_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: its own copy of the matrix and screen size.
  logic signed [31:0] model_matrix [16];
  logic [13:0] model_width;
  logic [13:0] model_height;

  in_item_t  pending_items [$];
  out_item_t expected_rects [$];

  int send_idle_pct = 6;
  int recv_idle_pct = 56;
  bit hold_start = 1'b0;   // asks the receiver for one long hold-off
  bit hold_active = 1'b0;  // high while that hold-off lasts
  int errors = 0;
  int cycles = 0;
  int boxes_sent = 0;
  int loads_sent = 0;
  int rects_checked = 0;

  function automatic logic signed [63:0] floor_q(input logic signed [127:0] v);
    return 64'(v >>> FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] clip_of(input int r,
                                                  input logic signed [63:0] p [3]);
    logic signed [63:0] acc;
    acc = 64'(model_matrix[r*4+3]);
    for (int j = 0; j < 3; j++)
      acc += floor_q(128'(model_matrix[r*4+j]) * 128'(p[j]));
    return acc;
  endfunction

  // c*ONE/d truncated toward zero, magnitude saturating at 2^47.
  function automatic logic signed [63:0] ratio_of(input logic signed [63:0] c,
                                                   input logic signed [63:0] d);
    logic [63:0] mag;
    logic [63:0] ud;
    logic [63:0] ip;
    logic [63:0] rem;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    ud = 64'(d);
    ip = mag / ud;
    rem = mag % ud;
    q = ip;
    if (ip >= (64'd1 << (47 - FRAC_BITS)))
      return (c < 0) ? -(64'sd1 <<< 47) : (64'sd1 <<< 47);
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ud) begin
        rem -= ud;
        q[0] = 1'b1;
      end
    end
    return (c < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic void predict_transfer(input in_item_t it);
    logic signed [63:0] lo [3];
    logic signed [63:0] hi [3];
    logic signed [63:0] p [3];
    logic signed [63:0] w, sx, sy, lft, tp, rgt, btm;
    logic signed [63:0] one;
    out_item_t r;
    int cnt;
    if (it.op == OP_LOAD) begin
      model_matrix[it.element_index] = it.element_value;
      return;
    end
    one = 64'sd1 <<< FRAC_BITS;
    lo = '{64'(it.min_x), 64'(it.min_y), 64'(it.min_z)};
    hi = '{64'(it.max_x), 64'(it.max_y), 64'(it.max_z)};
    lft = clamp32($signed({50'd0, model_width}) * one);
    tp = clamp32($signed({50'd0, model_height}) * one);
    rgt = 0;
    btm = 0;
    cnt = 0;
    for (int k = 0; k < 8; k++) begin
      p[0] = k[0] ? hi[0] : lo[0];
      p[1] = k[1] ? hi[1] : lo[1];
      p[2] = k[2] ? hi[2] : lo[2];
      w = clip_of(3, p);
      if (w < WMIN_VAL) continue;
      cnt++;
      sx = clamp32(($signed({50'd0, model_width}) * (one + ratio_of(clip_of(0, p), w))) >>> 1);
      sy = clamp32(($signed({50'd0, model_height}) * (one - ratio_of(clip_of(1, p), w))) >>> 1);
      if (sx < lft) lft = sx;
      if (sy < tp) tp = sy;
      if (sx > rgt) rgt = sx;
      if (sy > btm) btm = sy;
    end
    r.rect_left = lft[31:0];
    r.rect_top = tp[31:0];
    r.rect_right = rgt[31:0];
    r.rect_bottom = btm[31:0];
    r.visible_corners = 4'(cnt);
    expected_rects.push_back(r);
  endfunction

  // Driver: a transfer completes at an edge where valid is high and stall is low;
  // the payload is predicted at that point and the next one presented.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_transfer(in_data_i);
        if (in_data_i.op == OP_PROJECT) boxes_sent++;
        else loads_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process once it is asked for.
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // Monitor and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_rects.size() == 0) begin
          $error("result transfer with no rectangle expected");
          errors++;
        end else begin
          out_item_t e;
          e = expected_rects.pop_front();
          rects_checked++;
          if (out_data_o.rect_left !== e.rect_left) begin
            $error("rect_left expected %0d actual %0d", e.rect_left, out_data_o.rect_left);
            errors++;
          end
          if (out_data_o.rect_top !== e.rect_top) begin
            $error("rect_top expected %0d actual %0d", e.rect_top, out_data_o.rect_top);
            errors++;
          end
          if (out_data_o.rect_right !== e.rect_right) begin
            $error("rect_right expected %0d actual %0d", e.rect_right,
                   out_data_o.rect_right);
            errors++;
          end
          if (out_data_o.rect_bottom !== e.rect_bottom) begin
            $error("rect_bottom expected %0d actual %0d", e.rect_bottom,
                   out_data_o.rect_bottom);
            errors++;
          end
          if (out_data_o.visible_corners !== e.visible_corners) begin
            $error("visible_corners expected %0d actual %0d", e.visible_corners,
                   out_data_o.visible_corners);
            errors++;
          end
        end
      end
      if (hold_active) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 1'b0} << 1;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) model_width = val[13:0];
    else if (idx == REG_HEIGHT) model_height = val[13:0];
  endtask

  // Waits until every queued item has gone and every rectangle has come back,
  // then lets the block settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_rects.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t load_item(input int idx, input logic [31:0] v);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.element_index = 4'(idx);
    it.element_value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_q(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // A box around the origin within a few units, sometimes inverted or wild.
  function automatic in_item_t box_item(input bit wild);
    in_item_t it;
    it.op = OP_PROJECT;
    it.element_index = 4'($urandom);
    it.element_value = $urandom;
    if (wild) begin
      {it.min_x, it.min_y, it.min_z} = {$urandom, $urandom, $urandom};
      {it.max_x, it.max_y, it.max_z} = {$urandom, $urandom, $urandom};
    end else begin
      it.min_x = rand_q(5 << 16);
      it.min_y = rand_q(5 << 16);
      it.min_z = rand_q(5 << 16);
      it.max_x = it.min_x + $urandom_range(4 << 16);
      it.max_y = it.min_y + $urandom_range(4 << 16);
      it.max_z = it.min_z + $urandom_range(4 << 16);
    end
    return it;
  endfunction

  // A perspective-like matrix: w follows z plus an offset, with random scaling.
  task automatic queue_matrix(input bit wild);
    for (int i = 0; i < 16; i++) begin
      logic [31:0] v;
      if (wild) v = $urandom;
      else if (i == 0 || i == 5) v = 32'(1 << 16) + rand_q(1 << 16);
      else if (i == 14) v = 32'(1 << 16);
      else if (i == 15) v = 32'(6 << 16) + rand_q(3 << 16);
      else v = rand_q(1 << 14);
      pending_items.push_back(load_item(i, v));
    end
  endtask

  initial begin
    in_item_t it;
    for (int i = 0; i < 16; i++) model_matrix[i] = '0;
    model_width = 14'd1920;
    model_height = 14'd1080;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero matrix gives no visible corner, then extremes.
    it = box_item(0);
    pending_items.push_back(it);
    queue_matrix(0);
    it = box_item(0);
    pending_items.push_back(it);
    it.min_x = 32'sh8000_0000; it.min_y = 32'sh8000_0000; it.min_z = 32'sh8000_0000;
    it.max_x = 32'sh7fff_ffff; it.max_y = 32'sh7fff_ffff; it.max_z = 32'sh7fff_ffff;
    pending_items.push_back(it);
    it = box_item(0);  // inverted box
    {it.min_x, it.max_x} = {it.max_x, it.min_x};
    pending_items.push_back(it);
    pending_items.push_back(load_item(15, 32'sh7fff_ffff));
    pending_items.push_back(load_item(3, 32'sh8000_0000));
    pending_items.push_back(box_item(0));
    pending_items.push_back(load_item(15, 32'd66));  // w right at the near threshold
    pending_items.push_back(load_item(14, 32'd0));
    pending_items.push_back(box_item(0));
    pending_items.push_back(load_item(15, 32'd65));
    pending_items.push_back(box_item(0));
    drain();

    // Register extremes, including a zero width and a height beyond the usual range.
    apb_write(REG_WIDTH, 32'd0);
    apb_write(REG_HEIGHT, 32'hffff_ffff);
    queue_matrix(0);
    for (int i = 0; i < 3; i++) pending_items.push_back(box_item(0));
    drain();
    apb_write(REG_WIDTH, 32'd8192);
    apb_write(REG_HEIGHT, 32'd1);

    // Random phases: well-formed matrices and boxes, some noise.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 56;
        recv_idle_pct = 6;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(REG_WIDTH, 32'($urandom_range(1, 8192)));
        apb_write(REG_HEIGHT, 32'($urandom_range(1, 8192)));
      end
      for (int n = 0; n < 10; n++) begin
        queue_matrix($urandom_range(9) == 0);
        for (int b = 0; b < 8; b++) pending_items.push_back(box_item($urandom_range(9) == 0));
      end
      if (phase == 0) begin
        hold_start = 1'b1;  // long receiver hold-off while items keep coming
      end
      drain();  // sender pauses until every rectangle has arrived
      if (phase == 0) begin
        apb_write(REG_WIDTH, 32'd640);
        apb_write(REG_HEIGHT, 32'd8192);
      end
    end

    $display("Covered %0d matrix loads and %0d box projections, %0d rectangles checked,",
             loads_sent, boxes_sent, rects_checked);
    $display("across screen sizes from zero to the 8192 maximum and three idling mixes.");
    if (errors == 0 && expected_rects.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
